/* hw/rtl/wrm_pkg.sv */
// ----------------------------------------------------------------------------
// Welford running statistics package
// Shared widths, constants and port structures for the running mean and
// variance block.
// ----------------------------------------------------------------------------
package wrm_pkg;

	localparam int FEATURES  = 64;
	localparam int IDX_W     = $clog2(FEATURES);
	localparam int IN_IDX_W  = 6;
	localparam int SAMPLE_W  = 32;
	localparam int M2_W      = 64;
	localparam int COUNT_W   = 32;
	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// 0.01 in Q32.32, rounded to nearest.
	localparam logic [M2_W-1:0] M2_SEED = 64'd42949673;

	localparam logic [M2_W-1:0] M2_MAX = {1'b0, {(M2_W-1){1'b1}}};
	localparam logic [M2_W-1:0] M2_MIN = {1'b1, {(M2_W-1){1'b0}}};

	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    addr;
		logic [SAMPLE_W-1:0] mean;
		logic [M2_W-1:0]     m2;
	} wrm_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} wrm_rd_t;

endpackage

/* hw/rtl/welford_running_mean_variance.sv */
// ----------------------------------------------------------------------------
// Welford running mean and variance
// Per-feature running mean and M2 over a stream of vectors, one element a beat.
// ----------------------------------------------------------------------------
// The block takes one vector element per input beat and returns one result
// beat holding that feature's updated mean (Q16.16), its updated sum of
// squared deviations M2 (Q32.32, saturating) and the count of the current
// vector. Items are processed one at a time. During the first vector an item
// goes from acceptance to result through the memory read with the seed step,
// then the write-back. In later vectors an item passes through the memory
// read, the divider load, the radix-2 divider that forms delta / count, the
// divider's done flag, the multiply, the accumulate and the write-back. The
// next element can be accepted in the same cycle as the result appears.
// A finished result sits in the output register, so the next element is
// accepted while the previous result still waits to be taken. Feature entries
// are read before they are first written only if the stream skips a feature
// in the first vector; what such an entry then returns is undefined.
module welford_running_mean_variance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [wrm_pkg::IN_IDX_W-1:0]  feature_index,
	input  logic signed [wrm_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                          vector_end,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [wrm_pkg::SAMPLE_W-1:0] mean_value,
	output logic signed [wrm_pkg::M2_W-1:0]     squared_deviation_sum,
	output logic [wrm_pkg::COUNT_W-1:0]         vector_count
);
	import wrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_DIV,
		S_MUL,
		S_ACC,
		S_DONE
	} state_t;

	state_t              state_q;

	// Item registers, held for the whole update.
	logic [SAMPLE_W-1:0] x_q;
	logic [IDX_W-1:0]    idx_q;
	logic                last_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [M2_W-1:0]     m2_old_q;
	logic [SAMPLE_W-1:0] mag1_q;
	logic                neg1_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [M2_W-1:0]     prod_q;
	logic                negp_q;
	logic [M2_W-1:0]     m2_q;
	logic [COUNT_W-1:0]  step_count_q;

	// Output register.
	logic                result_valid_q;
	logic [SAMPLE_W-1:0] mean_value_q;
	logic [M2_W-1:0]     m2_value_q;
	logic [COUNT_W-1:0]  vector_count_q;

	wrm_wr_t             wr;
	wrm_rd_t             rd;
	logic [SAMPLE_W-1:0] rd_mean;
	logic [M2_W-1:0]     rd_m2;

	logic                accept;
	logic                out_free;
	logic                div_start;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	logic [SAMPLE_W:0]   d1_w;
	logic [SAMPLE_W:0]   mag1_w;
	logic [SAMPLE_W:0]   new_mean_w;
	logic [SAMPLE_W:0]   d2_w;
	logic [SAMPLE_W:0]   mag2_w;
	logic [M2_W-1:0]     prod_w;
	logic                negp_w;
	logic [M2_W+1:0]     sum_w;
	logic [M2_W-1:0]     sat_w;

	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign div_start    = (state_q == S_LOAD);

	// The memory is read on the beat that accepts the item; the data is
	// there in the following cycle. The write-back lands before any later
	// item can be accepted, so a read never overlaps a pending write.
	assign rd.en   = accept;
	assign rd.addr = feature_index[IDX_W-1:0];

	assign wr.en   = (state_q == S_DONE) && out_free;
	assign wr.addr = idx_q;
	assign wr.mean = mean_q;
	assign wr.m2   = m2_q;

	wrm_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_mean (rd_mean),
		.rd_m2   (rd_m2)
	);

	wrm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag1_q),
		.divisor  (step_count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// delta = x - mean. Both are Q16.16, so the magnitude of the difference
	// always fits 32 bits even though the signed difference needs 33.
	assign d1_w   = {x_q[SAMPLE_W-1], x_q} - {rd_mean[SAMPLE_W-1], rd_mean};
	assign mag1_w = d1_w[SAMPLE_W] ? (~d1_w + 1'b1) : d1_w;

	// The quotient takes the sign of delta, which keeps the new mean between
	// the old mean and the sample, so it always fits Q16.16.
	assign new_mean_w = neg1_q ? ({old_q[SAMPLE_W-1], old_q} - {1'b0, div_quo})
	                           : ({old_q[SAMPLE_W-1], old_q} + {1'b0, div_quo});

	assign d2_w   = {x_q[SAMPLE_W-1], x_q} - {mean_q[SAMPLE_W-1], mean_q};
	assign mag2_w = d2_w[SAMPLE_W] ? (~d2_w + 1'b1) : d2_w;
	assign prod_w = mag1_q * mag2_w[SAMPLE_W-1:0];
	assign negp_w = (neg1_q != d2_w[SAMPLE_W]) && (prod_w != '0);

	// Saturating accumulate into M2. Two guard bits hold any sum of a signed
	// 64-bit value and an unsigned 64-bit product.
	assign sum_w = negp_q ? ({{2{m2_old_q[M2_W-1]}}, m2_old_q} - {2'b00, prod_q})
	                      : ({{2{m2_old_q[M2_W-1]}}, m2_old_q} + {2'b00, prod_q});

	always_comb begin
		if ((sum_w[M2_W+1] == sum_w[M2_W]) && (sum_w[M2_W] == sum_w[M2_W-1])) begin
			sat_w = sum_w[M2_W-1:0];
		end else if (sum_w[M2_W+1]) begin
			sat_w = M2_MIN;
		end else begin
			sat_w = M2_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_count_q   <= COUNT_W'(1);
			result_valid_q <= 1'b0;
			mean_value_q   <= '0;
			m2_value_q     <= '0;
			vector_count_q <= '0;
			x_q            <= '0;
			idx_q          <= '0;
			last_q         <= 1'b0;
			old_q          <= '0;
			m2_old_q       <= '0;
			mag1_q         <= '0;
			neg1_q         <= 1'b0;
			mean_q         <= '0;
			prod_q         <= '0;
			negp_q         <= 1'b0;
			m2_q           <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						x_q     <= sample_value;
						idx_q   <= feature_index[IDX_W-1:0];
						last_q  <= vector_end;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					old_q    <= rd_mean;
					m2_old_q <= rd_m2;
					if (step_count_q == COUNT_W'(1)) begin
						// First vector: the sample seeds the mean, M2 starts at 0.01.
						mean_q  <= x_q;
						m2_q    <= M2_SEED;
						state_q <= S_DONE;
					end else begin
						mag1_q  <= mag1_w[SAMPLE_W-1:0];
						neg1_q  <= d1_w[SAMPLE_W];
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						mean_q  <= new_mean_w[SAMPLE_W-1:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_w;
					negp_q  <= negp_w;
					state_q <= S_ACC;
				end
				S_ACC: begin
					m2_q    <= sat_w;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						mean_value_q   <= mean_q;
						m2_value_q     <= m2_q;
						vector_count_q <= step_count_q;
						if (last_q && (step_count_q != {COUNT_W{1'b1}})) begin
							step_count_q <= step_count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid          = result_valid_q;
	assign mean_value            = mean_value_q;
	assign squared_deviation_sum = m2_value_q;
	assign vector_count          = vector_count_q;

endmodule

/* hw/rtl/wrm_store.sv */
// ----------------------------------------------------------------------------
// Per-feature state memory
// Holds the running mean and M2 of every feature in one synchronous memory
// with a registered read port and a single write port.
// ----------------------------------------------------------------------------
module wrm_store (
	input  logic                      clk,
	input  wrm_pkg::wrm_wr_t          wr,
	input  wrm_pkg::wrm_rd_t          rd,
	output logic [wrm_pkg::SAMPLE_W-1:0] rd_mean,
	output logic [wrm_pkg::M2_W-1:0]     rd_m2
);
	import wrm_pkg::*;

	logic [SAMPLE_W-1:0] mean_mem [FEATURES];
	logic [M2_W-1:0]     m2_mem   [FEATURES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mean_mem[wr.addr] <= wr.mean;
			m2_mem[wr.addr]   <= wr.m2;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_mean <= mean_mem[rd.addr];
			rd_m2   <= m2_mem[rd.addr];
		end
	end

endmodule

/* hw/rtl/wrm_divider.sv */
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle, with a single-cycle
// done pulse once the quotient is complete.
// ----------------------------------------------------------------------------
module wrm_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wrm_pkg::DIV_W-1:0] dividend,
	input  logic [wrm_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [wrm_pkg::DIV_W-1:0] quotient
);
	import wrm_pkg::*;

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 fits;

	// The remainder stays below the divisor, so the shifted value fits DIV_W+1 bits.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				dvs_q <= divisor;
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/wrm_checker.sv */
// ----------------------------------------------------------------------------
// Port checker for the Welford running statistics block
// Watches the top-level ports and flags handshake and result inconsistencies.
// ----------------------------------------------------------------------------
module wrm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic [wrm_pkg::IN_IDX_W-1:0]  feature_index,
	input logic signed [wrm_pkg::SAMPLE_W-1:0] sample_value,
	input logic                          vector_end,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [wrm_pkg::SAMPLE_W-1:0] mean_value,
	input logic signed [wrm_pkg::M2_W-1:0]     squared_deviation_sum,
	input logic [wrm_pkg::COUNT_W-1:0]         vector_count
);
	import wrm_pkg::*;

	// A stalled result beat stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat withdrawn before it was taken");

	// A stalled result beat keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(mean_value)
			&& $stable(squared_deviation_sum) && $stable(vector_count))
		else $error("result payload changed while stalled");

	// Items are worked on one at a time, so input is refused right after a beat.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("second item accepted while one is in flight");

	// The vector count starts at one and never wraps to zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> vector_count != '0)
		else $error("vector count of zero reported");

	// During the first vector M2 is always the seed value.
	a_first_seed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (vector_count == COUNT_W'(1))
			|-> squared_deviation_sum == $signed(M2_SEED))
		else $error("first-vector M2 differs from the seed");

endmodule

bind welford_running_mean_variance wrm_checker u_wrm_checker (.*);
